// ===== rtl/core/tafp_pkg.sv =====
// Shared types, constants and phase helpers for the TS adaptation field parser.
// Used by tafp_parser, tafp_queue and ts_adaptation_field_parser.
package tafp_pkg;

    // Parse phases, in field order
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_FLAGS    = 4'd1,
        PH_PCR      = 4'd2,
        PH_OPCR     = 4'd3,
        PH_CD       = 4'd4,
        PH_PRIVLEN  = 4'd5,
        PH_PRIVSKIP = 4'd6,
        PH_EXTLEN   = 4'd7,
        PH_EXTFLAGS = 4'd8,
        PH_LTW      = 4'd9,
        PH_RATE     = 4'd10,
        PH_SPLICE   = 4'd11,
        PH_EXTSKIP  = 4'd12,
        PH_STUFF    = 4'd13
    } t_phase;

    // Element kind codes
    localparam logic [3:0] KIND_LENGTH    = 4'd0;
    localparam logic [3:0] KIND_FLAGS     = 4'd1;
    localparam logic [3:0] KIND_PCR       = 4'd2;
    localparam logic [3:0] KIND_OPCR      = 4'd3;
    localparam logic [3:0] KIND_COUNTDOWN = 4'd4;
    localparam logic [3:0] KIND_PRIVLEN   = 4'd5;
    localparam logic [3:0] KIND_EXTHDR    = 4'd6;
    localparam logic [3:0] KIND_LTW       = 4'd7;
    localparam logic [3:0] KIND_RATE      = 4'd8;
    localparam logic [3:0] KIND_SPLICE    = 4'd9;
    localparam logic [3:0] KIND_END       = 4'd10;

    localparam int VALUE_W  = 42;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 48;   // overrun + value, padded to bytes
    localparam int KIND_W   = 4;

    // Element queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               overrun;
        logic               last;
    } t_elem;

    // Up to two elements per request, in emission order
    typedef struct packed {
        logic  valid0;
        t_elem elem0;
        logic  valid1;
        t_elem elem1;
    } t_emit;

    // Next phase in field order for multi-byte elements
    function automatic t_phase phase_succ(input t_phase p);
        t_phase q;
        case (p)
            PH_PCR:    q = PH_OPCR;
            PH_OPCR:   q = PH_CD;
            PH_LTW:    q = PH_RATE;
            PH_RATE:   q = PH_SPLICE;
            PH_SPLICE: q = PH_EXTSKIP;
            default:   q = p;
        endcase
        return q;
    endfunction

    // First phase at or after p that is present in this field
    function automatic t_phase settle(input t_phase p, input logic [7:0] mf,
                                      input logic [2:0] ef, input logic skip_nz);
        t_phase q;
        q = p;
        if (q == PH_PCR && !mf[4])       q = PH_OPCR;
        if (q == PH_OPCR && !mf[3])      q = PH_CD;
        if (q == PH_CD && !mf[2])        q = PH_PRIVLEN;
        if (q == PH_PRIVLEN && !mf[1])   q = PH_EXTLEN;
        if (q == PH_PRIVSKIP && !skip_nz) q = PH_EXTLEN;
        if (q == PH_EXTLEN && !mf[0])    q = PH_STUFF;
        if (q == PH_LTW && !ef[2])       q = PH_RATE;
        if (q == PH_RATE && !ef[1])      q = PH_SPLICE;
        if (q == PH_SPLICE && !ef[0])    q = PH_EXTSKIP;
        if (q == PH_EXTSKIP && !skip_nz) q = PH_STUFF;
        return q;
    endfunction

endpackage

// ===== rtl/core/tafp_parser.sv =====
// Front end: byte-wise adaptation field parser, emits up to two elements per byte.
// Depends on tafp_pkg.
module tafp_parser import tafp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [IN_DW-1:0] i_byte,
    input  logic             i_start,
    output t_emit            o_emit
);

    t_phase      r_phase, n_phase, w_phase_step;
    logic [2:0]  r_bie, n_bie;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_mf, n_mf;
    logic [2:0]  r_ef, n_ef;
    logic [47:0] r_asm, n_asm;
    logic [7:0]  r_skip, n_skip;
    logic        r_ovs, n_ovs;

    logic [47:0] w_asm_shift;
    logic [2:0]  w_bie_inc;
    logic [7:0]  w_rem_dec;
    logic        w_in_ext;
    logic [2:0]  w_ef_ext;
    logic [7:0]  w_skip_ext;
    logic [7:0]  w_skip_priv;
    logic        w_ovs_ext;
    logic        w_active;
    logic        w_elem_done;

    assign w_asm_shift = {r_asm[39:0], i_byte};
    assign w_bie_inc   = r_bie + 3'd1;
    assign w_rem_dec   = r_rem - 8'd1;
    assign w_in_ext    = (r_phase >= PH_EXTFLAGS) && (r_phase <= PH_EXTSKIP);
    assign w_ef_ext    = (r_phase == PH_EXTFLAGS) ? i_byte[7:5] : r_ef;
    assign w_skip_ext  = (w_in_ext && r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
    assign w_skip_priv = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
    assign w_ovs_ext   = r_ovs | (w_in_ext && r_skip == 8'd0);
    assign w_active    = !i_start && (r_phase != PH_IDLE) && (r_rem != 8'd0);

    assign w_elem_done =
        ((r_phase == PH_PCR || r_phase == PH_OPCR) && w_bie_inc >= 3'd6) ||
        (r_phase == PH_LTW    && w_bie_inc >= 3'd2) ||
        (r_phase == PH_RATE   && w_bie_inc >= 3'd3) ||
        (r_phase == PH_SPLICE && w_bie_inc >= 3'd5);

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_bie        = r_bie;
        n_rem        = r_rem;
        n_mf         = r_mf;
        n_ef         = r_ef;
        n_asm        = r_asm;
        n_skip       = r_skip;
        n_ovs        = r_ovs;
        w_phase_step = r_phase;
        if (i_start) begin
            n_bie   = 3'd0;
            n_rem   = i_byte;
            n_mf    = 8'd0;
            n_ef    = 3'd0;
            n_asm   = 48'd0;
            n_skip  = 8'd0;
            n_ovs   = 1'b0;
            n_phase = (i_byte == 8'd0) ? PH_IDLE : PH_FLAGS;
        end else if (!w_active) begin
            n_phase = PH_IDLE;
        end else begin
            n_rem  = w_rem_dec;
            n_ef   = w_ef_ext;
            n_skip = w_skip_ext;
            n_ovs  = w_ovs_ext;
            case (r_phase)
                PH_FLAGS: begin
                    n_mf         = i_byte;
                    w_phase_step = settle(PH_PCR, i_byte, w_ef_ext, w_skip_ext != 8'd0);
                end
                PH_PCR, PH_OPCR, PH_LTW, PH_RATE, PH_SPLICE: begin
                    n_asm = w_asm_shift;
                    n_bie = w_bie_inc;
                    if (w_elem_done) begin
                        n_asm        = 48'd0;
                        n_bie        = 3'd0;
                        w_phase_step = settle(phase_succ(r_phase), r_mf, w_ef_ext,
                                              w_skip_ext != 8'd0);
                    end
                end
                PH_CD: begin
                    w_phase_step = settle(PH_PRIVLEN, r_mf, w_ef_ext, w_skip_ext != 8'd0);
                end
                PH_PRIVLEN: begin
                    n_skip       = i_byte;
                    w_phase_step = settle(PH_PRIVSKIP, r_mf, w_ef_ext, i_byte != 8'd0);
                end
                PH_PRIVSKIP: begin
                    n_skip = w_skip_priv;
                    if (w_skip_priv == 8'd0) begin
                        w_phase_step = settle(PH_EXTLEN, r_mf, w_ef_ext, 1'b0);
                    end
                end
                PH_EXTLEN: begin
                    n_skip       = i_byte;
                    w_phase_step = PH_EXTFLAGS;
                end
                PH_EXTFLAGS: begin
                    w_phase_step = settle(PH_LTW, r_mf, w_ef_ext, w_skip_ext != 8'd0);
                end
                PH_EXTSKIP: begin
                    if (w_skip_ext == 8'd0) w_phase_step = PH_STUFF;
                end
                default: begin
                end
            endcase
            n_phase = w_phase_step;
            // declared length used up: close the field
            if (w_rem_dec == 8'd0) begin
                n_phase = PH_IDLE;
                n_bie   = 3'd0;
                n_rem   = 8'd0;
                n_mf    = 8'd0;
                n_ef    = 3'd0;
                n_asm   = 48'd0;
                n_skip  = 8'd0;
                n_ovs   = 1'b0;
            end
        end
    end

    // Emitted elements
    always_comb begin
        o_emit = '0;
        if (i_accept) begin
            if (i_start) begin
                o_emit.valid0     = 1'b1;
                o_emit.elem0.kind  = KIND_LENGTH;
                o_emit.elem0.value = VALUE_W'(i_byte);
                if (i_byte == 8'd0) begin
                    o_emit.valid1     = 1'b1;
                    o_emit.elem1.kind = KIND_END;
                    o_emit.elem1.last = 1'b1;
                end
            end else if (w_active) begin
                case (r_phase)
                    PH_FLAGS: begin
                        o_emit.valid0      = 1'b1;
                        o_emit.elem0.kind  = KIND_FLAGS;
                        o_emit.elem0.value = VALUE_W'(i_byte);
                    end
                    PH_PCR, PH_OPCR: begin
                        o_emit.valid0      = w_elem_done;
                        o_emit.elem0.kind  = (r_phase == PH_PCR) ? KIND_PCR : KIND_OPCR;
                        o_emit.elem0.value = {w_asm_shift[47:15], w_asm_shift[8:0]};
                    end
                    PH_CD: begin
                        o_emit.valid0      = 1'b1;
                        o_emit.elem0.kind  = KIND_COUNTDOWN;
                        o_emit.elem0.value = VALUE_W'(i_byte);
                    end
                    PH_PRIVLEN: begin
                        o_emit.valid0      = 1'b1;
                        o_emit.elem0.kind  = KIND_PRIVLEN;
                        o_emit.elem0.value = VALUE_W'(i_byte);
                    end
                    PH_EXTFLAGS: begin
                        // extension length before this byte is counted, then flags
                        o_emit.valid0      = 1'b1;
                        o_emit.elem0.kind  = KIND_EXTHDR;
                        o_emit.elem0.value = VALUE_W'({r_skip, i_byte[7:5]});
                    end
                    PH_LTW: begin
                        o_emit.valid0      = w_elem_done;
                        o_emit.elem0.kind  = KIND_LTW;
                        o_emit.elem0.value = VALUE_W'(w_asm_shift[15:0]);
                    end
                    PH_RATE: begin
                        o_emit.valid0      = w_elem_done;
                        o_emit.elem0.kind  = KIND_RATE;
                        o_emit.elem0.value = VALUE_W'(w_asm_shift[21:0]);
                    end
                    PH_SPLICE: begin
                        // type, then DTS with marker bits dropped
                        o_emit.valid0      = w_elem_done;
                        o_emit.elem0.kind  = KIND_SPLICE;
                        o_emit.elem0.value = VALUE_W'({w_asm_shift[39:33],
                                                       w_asm_shift[31:17],
                                                       w_asm_shift[15:1]});
                    end
                    default: begin
                    end
                endcase
                if (w_rem_dec == 8'd0) begin
                    o_emit.valid1        = 1'b1;
                    o_emit.elem1.kind    = KIND_END;
                    o_emit.elem1.overrun = w_ovs_ext || (w_phase_step != PH_STUFF);
                    o_emit.elem1.last    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bie   <= 3'd0;
            r_rem   <= 8'd0;
            r_mf    <= 8'd0;
            r_ef    <= 3'd0;
            r_asm   <= 48'd0;
            r_skip  <= 8'd0;
            r_ovs   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bie   <= n_bie;
            r_rem   <= n_rem;
            r_mf    <= n_mf;
            r_ef    <= n_ef;
            r_asm   <= n_asm;
            r_skip  <= n_skip;
            r_ovs   <= n_ovs;
        end
    end

endmodule

// ===== rtl/core/tafp_queue.sv =====
// Back end: short element queue taking up to two elements a cycle, one out.
// Depends on tafp_pkg.
module tafp_queue import tafp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_emit i_emit,
    input  logic  i_pop,
    output t_elem o_head,
    output logic  o_valid,
    output logic  o_room
);

    t_elem          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic [1:0]     w_nwr;
    t_elem          w_first;
    logic           w_pop;

    assign w_nwr   = {1'b0, i_emit.valid0} + {1'b0, i_emit.valid1};
    assign w_first = i_emit.valid0 ? i_emit.elem0 : i_emit.elem1;
    assign o_valid = (r_cnt != '0);
    assign w_pop   = i_pop && o_valid;
    assign o_head  = r_mem[r_rp];
    // room for a full two-element request
    assign o_room  = (r_cnt <= QCW'(QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (w_nwr != 2'd0) r_mem[r_wp] <= w_first;
        if (w_nwr == 2'd2) r_mem[r_wp + QAW'(1)] <= i_emit.elem1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(w_nwr);
            r_rp  <= r_rp + QAW'(w_pop);
            r_cnt <= r_cnt + QCW'(w_nwr) - QCW'(w_pop);
        end
    end

endmodule

// ===== rtl/core/ts_adaptation_field_parser.sv =====
// TS adaptation field parser top: parser front end, element queue back end.
// Output: an element appears on the master side in the cycle after its byte's request when
// the queue is empty; otherwise it waits behind the elements queued ahead of it.
// Throughput: one byte per cycle while the queue has room; a byte may yield two elements
// (element plus end), the master side drains one element per cycle while m_axis_tready is
// high, and the slave side stalls while the queue holds more than two elements.
// Reset: synchronous active-low i_rst_n; parser idles awaiting a start, queue empties.
module ts_adaptation_field_parser import tafp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic [0:0]        s_axis_tuser,   // [0] field_start (length byte)
    // parsed elements out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // [41:0] element_value, [42] overrun, zero pad
    output logic [KIND_W-1:0] m_axis_tuser,   // [3:0] element_kind
    output logic              m_axis_tlast    // last_of_field
);

    t_emit w_emit;
    t_elem w_head;
    logic  w_room;
    logic  w_accept;

    // Input is taken only while the queue can absorb a worst-case request
    // (two elements), so the front end never needs to stall mid-byte.
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Front end: classifies each byte by parse phase and assembles elements
    tafp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .o_emit   (w_emit)
    );

    // Back end: element queue feeding the master side
    tafp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_pop   (m_axis_tready),
        .o_head  (w_head),
        .o_valid (m_axis_tvalid),
        .o_room  (w_room)
    );

    assign m_axis_tdata = {{(OUT_DW - VALUE_W - 1){1'b0}}, w_head.overrun, w_head.value};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

`ifndef ASSERT_OFF
    // only the end element closes a field
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_END))
        else $error("tlast on non-end element");

    // overrun is reported on the end element only
    a_overrun_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_END) |-> !m_axis_tdata[VALUE_W])
        else $error("overrun set on non-end element");

    // front end stalls only while the queue holds elements
    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty queue");

    // a length byte always yields an element the next cycle
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> m_axis_tvalid)
        else $error("length byte produced no element");
`endif

endmodule

// ===== verif/ts_adaptation_field_parser_tb.sv =====
// Self-checking testbench for ts_adaptation_field_parser: directed rows, then random fields.
// Depends on tafp_pkg (kind codes, t_phase, t_elem) and the parser RTL; needs nothing else.
`timescale 1ns / 1ps

module ts_adaptation_field_parser_tb;
    import tafp_pkg::*;

    // one directed row: byte, start mark, optional hand-typed element for that request
    typedef struct packed {
        logic [7:0] b;
        logic       st;
        logic       pin;
        logic       pidx;
        t_elem      want;
    } t_row;

    localparam t_elem UNPINNED = '0;
    localparam int RANDOM_ITEMS = 1350;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [7:0]        s_data = '0;
    logic [0:0]        s_user = '0;
    logic              m_ready = 1'b0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;
    logic              m_axis_tlast;

    // hand-typed expectation travels with the request it belongs to
    logic  pin_en = 1'b0;
    logic  pin_idx = 1'b0;
    t_elem pin_elem = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 64;
    int err_count = 0;
    int items_sent = 0;
    int bytes_in = 0;
    int elems_checked = 0;
    int overrun_ends = 0;
    int kind_hits[11];
    int step_emits;

    t_row  dir_rows[$];
    t_elem pending_elems[$];

    // shadow of the parser state
    t_phase      af_phase = PH_IDLE;
    logic [2:0]  af_pos = '0;
    logic [7:0]  af_left = '0;
    logic [7:0]  af_flags = '0;
    logic [2:0]  af_ext = '0;
    logic [47:0] af_shift = '0;
    logic [7:0]  af_skip = '0;
    logic        af_over = 1'b0;

    ts_adaptation_field_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d elements outstanding", pending_elems.size());
        $display("ts_adaptation_field_parser test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void clear_field();
        af_pos   = '0;
        af_left  = '0;
        af_flags = '0;
        af_ext   = '0;
        af_shift = '0;
        af_skip  = '0;
        af_over  = 1'b0;
    endfunction

    // at most two elements per request
    function automatic void queue_elem(input logic [3:0] kind, input logic [41:0] value,
                                       input logic ov, input logic last);
        t_elem e;
        if (step_emits < 2) begin
            e.kind    = kind;
            e.value   = value;
            e.overrun = ov;
            e.last    = last;
            pending_elems.push_back(e);
        end
        step_emits++;
    endfunction

    // skip forward past elements whose flag is clear
    function automatic t_phase present_phase(input t_phase p);
        t_phase q;
        logic   done;
        q = p;
        done = 1'b0;
        while (!done) begin
            case (q)
                PH_PCR:      if (af_flags[4]) done = 1'b1; else q = PH_OPCR;
                PH_OPCR:     if (af_flags[3]) done = 1'b1; else q = PH_CD;
                PH_CD:       if (af_flags[2]) done = 1'b1; else q = PH_PRIVLEN;
                PH_PRIVLEN:  if (af_flags[1]) done = 1'b1; else q = PH_EXTLEN;
                PH_PRIVSKIP: if (af_skip != 0) done = 1'b1; else q = PH_EXTLEN;
                PH_EXTLEN: begin
                    if (!af_flags[0]) q = PH_STUFF;
                    done = 1'b1;
                end
                PH_LTW:      if (af_ext[2]) done = 1'b1; else q = PH_RATE;
                PH_RATE:     if (af_ext[1]) done = 1'b1; else q = PH_SPLICE;
                PH_SPLICE:   if (af_ext[0]) done = 1'b1; else q = PH_EXTSKIP;
                PH_EXTSKIP: begin
                    if (af_skip == 0) q = PH_STUFF;
                    done = 1'b1;
                end
                default:     done = 1'b1;
            endcase
        end
        return q;
    endfunction

    // expected elements for one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic st);
        logic [47:0] a;
        logic [32:0] dts;
        logic        done_elem;
        if (st) begin
            clear_field();
            af_left = b;
            queue_elem(KIND_LENGTH, 42'(b), 1'b0, 1'b0);
            if (b == 0) begin
                queue_elem(KIND_END, '0, 1'b0, 1'b1);
                af_phase = PH_IDLE;
            end else begin
                af_phase = PH_FLAGS;
            end
            return;
        end
        if (af_phase == PH_IDLE || af_left == 0) begin
            af_phase = PH_IDLE;
            return;
        end
        af_left = af_left - 8'd1;

        // every extension byte counts against the extension length
        if (af_phase >= PH_EXTFLAGS && af_phase <= PH_EXTSKIP) begin
            if (af_phase == PH_EXTFLAGS) begin
                af_ext = b[7:5];
                queue_elem(KIND_EXTHDR, 42'({af_skip, af_ext}), 1'b0, 1'b0);
            end
            if (af_skip == 0) af_over = 1'b1;
            else af_skip = af_skip - 8'd1;
        end

        case (af_phase)
            PH_FLAGS: begin
                af_flags = b;
                queue_elem(KIND_FLAGS, 42'(b), 1'b0, 1'b0);
                af_phase = present_phase(PH_PCR);
            end
            PH_PCR, PH_OPCR: begin
                af_shift = {af_shift[39:0], b};
                af_pos = af_pos + 3'd1;
                if (af_pos >= 3'd6) begin
                    a = af_shift;
                    // 33-bit base, 6 reserved bits dropped, 9-bit extension
                    queue_elem(af_phase == PH_PCR ? KIND_PCR : KIND_OPCR,
                               {a[47:15], a[8:0]}, 1'b0, 1'b0);
                    af_pos = '0;
                    af_shift = '0;
                    af_phase = present_phase(t_phase'(af_phase + 4'd1));
                end
            end
            PH_CD: begin
                queue_elem(KIND_COUNTDOWN, 42'(b), 1'b0, 1'b0);
                af_phase = present_phase(PH_PRIVLEN);
            end
            PH_PRIVLEN: begin
                queue_elem(KIND_PRIVLEN, 42'(b), 1'b0, 1'b0);
                af_skip = b;
                af_phase = present_phase(PH_PRIVSKIP);
            end
            PH_PRIVSKIP: begin
                if (af_skip != 0) af_skip = af_skip - 8'd1;
                if (af_skip == 0) af_phase = present_phase(PH_EXTLEN);
            end
            PH_EXTLEN: begin
                af_skip = b;
                af_phase = PH_EXTFLAGS;
            end
            PH_EXTFLAGS: af_phase = present_phase(PH_LTW);
            PH_LTW, PH_RATE, PH_SPLICE: begin
                af_shift = {af_shift[39:0], b};
                af_pos = af_pos + 3'd1;
                a = af_shift;
                done_elem = 1'b1;
                if (af_phase == PH_LTW && af_pos >= 3'd2) begin
                    queue_elem(KIND_LTW, 42'(a[15:0]), 1'b0, 1'b0);
                end else if (af_phase == PH_RATE && af_pos >= 3'd3) begin
                    queue_elem(KIND_RATE, 42'(a[21:0]), 1'b0, 1'b0);
                end else if (af_phase == PH_SPLICE && af_pos >= 3'd5) begin
                    // DTS pieces sit between marker bits
                    dts = {a[35:33], a[31:24], a[23:17], a[15:8], a[7:1]};
                    queue_elem(KIND_SPLICE, 42'({a[39:36], dts}), 1'b0, 1'b0);
                end else begin
                    done_elem = 1'b0;
                end
                if (done_elem) begin
                    af_pos = '0;
                    af_shift = '0;
                    af_phase = present_phase(t_phase'(af_phase + 4'd1));
                end
            end
            PH_EXTSKIP: if (af_skip == 0) af_phase = PH_STUFF;
            default: ;
        endcase

        if (af_left == 0) begin
            queue_elem(KIND_END, '0, af_over || af_phase != PH_STUFF, 1'b1);
            af_phase = PH_IDLE;
            clear_field();
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // predict on each accepted request, check each accepted element against the oldest
    always @(posedge i_clk) begin : scoreboard
        int    base;
        t_elem want;
        if (i_rst_n) begin
            if (s_valid && s_axis_tready) begin
                base = pending_elems.size();
                step_emits = 0;
                bytes_in++;
                parse_byte(s_data, s_user[0]);
                if (pin_en && base + pin_idx < pending_elems.size())
                    pending_elems[base + pin_idx] = pin_elem;
            end
            if (m_axis_tvalid && m_ready) begin
                if (pending_elems.size() == 0) begin
                    note_mismatch("element with nothing pending (kind)", 64'(m_axis_tuser), '0);
                end else begin
                    want = pending_elems.pop_front();
                    elems_checked++;
                    if (want.kind <= KIND_END) kind_hits[want.kind]++;
                    if (want.kind == KIND_END && want.overrun) overrun_ends++;
                    if (m_axis_tuser !== want.kind)
                        note_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
                    if (m_axis_tdata[VALUE_W-1:0] !== want.value)
                        note_mismatch("value", 64'(m_axis_tdata[VALUE_W-1:0]), 64'(want.value));
                    if (m_axis_tdata[VALUE_W] !== want.overrun)
                        note_mismatch("overrun", 64'(m_axis_tdata[VALUE_W]), 64'(want.overrun));
                    if (m_axis_tlast !== want.last)
                        note_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
                    if (m_axis_tdata[OUT_DW-1:VALUE_W+1] !== '0)
                        note_mismatch("tdata pad", 64'(m_axis_tdata[OUT_DW-1:VALUE_W+1]), '0);
                end
            end
        end
    end

    // one request; an idle gap drops valid first, never in the same step it rises
    task automatic send_byte(input logic [7:0] b, input logic st, input logic pin,
                             input logic pidx, input t_elem want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_valid  <= 1'b1;
        s_data   <= b;
        s_user   <= st;
        pin_en   <= pin;
        pin_idx  <= pidx;
        pin_elem <= want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // mostly well-formed fields with random content; some broken or noisy
    task automatic send_random_field();
        logic [7:0] body[$];
        logic [7:0] fl;
        logic [7:0] plen;
        logic [7:0] elen;
        logic [7:0] decl;
        logic [2:0] ef;
        int         mode;
        int         need;
        int         extra;
        int         n_send;
        mode = $urandom_range(99);
        if (mode < 5) begin
            // stray bytes between fields, ignored unless a field is still open
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0,
                                                    1'b0, UNPINNED);
            return;
        end
        if (mode < 9) begin
            send_byte(8'h00, 1'b1, 1'b0, 1'b0, UNPINNED);
            items_sent++;
            return;
        end
        fl = 8'($urandom_range(255));
        body.push_back(fl);
        if (fl[4]) repeat (6) body.push_back(8'($urandom_range(255)));
        if (fl[3]) repeat (6) body.push_back(8'($urandom_range(255)));
        if (fl[2]) body.push_back(8'($urandom_range(255)));
        if (fl[1]) begin
            // a rare long private block can push the length byte past 127
            plen = ($urandom_range(29) == 0) ? 8'($urandom_range(120, 180))
                                             : 8'($urandom_range(4));
            body.push_back(plen);
            repeat (plen) body.push_back(8'($urandom_range(255)));
        end
        if (fl[0]) begin
            ef = 3'($urandom_range(7));
            need = 1 + (ef[2] ? 2 : 0) + (ef[1] ? 3 : 0) + (ef[0] ? 5 : 0);
            extra = $urandom_range(2);
            elen = (mode < 15) ? 8'($urandom_range(need - 1)) : 8'(need + extra);
            body.push_back(elen);
            body.push_back({ef, 5'($urandom_range(31))});
            repeat (need - 1 + extra) body.push_back(8'($urandom_range(255)));
        end
        repeat ($urandom_range(3)) body.push_back(8'hFF);
        decl = 8'(body.size());
        n_send = body.size();
        if (mode >= 15 && mode < 22) begin
            // declared length may cut the field short
            decl = 8'($urandom_range(1, body.size()));
            n_send = decl;
        end else if (mode >= 22 && mode < 27) begin
            // next start arrives before this field is done
            n_send = $urandom_range(0, body.size() - 1);
        end
        send_byte(decl, 1'b1, 1'b0, 1'b0, UNPINNED);
        for (int i = 0; i < n_send; i++) send_byte(body[i], 1'b0, 1'b0, 1'b0, UNPINNED);
        items_sent += 1 + n_send;
    endtask

    initial begin
        // byte, start, pin, pin index, typed element {kind, value, overrun, last}
        dir_rows.push_back({8'h55, 1'b0, 1'b0, 1'b0, UNPINNED});   // idle byte, dropped
        dir_rows.push_back({8'h00, 1'b1, 1'b1, 1'b1, KIND_END, 42'd0, 1'b0, 1'b1});
        // length 1, no flags: exact fit
        dir_rows.push_back({8'h01, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h00, 1'b0, 1'b1, 1'b1, KIND_END, 42'd0, 1'b0, 1'b1});
        // countdown only, max value, ends with the field
        dir_rows.push_back({8'h02, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h04, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'hFF, 1'b0, 1'b1, 1'b0, KIND_COUNTDOWN, 42'hFF, 1'b0, 1'b0});
        // PCR of all ones
        dir_rows.push_back({8'h07, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h10, 1'b0, 1'b0, 1'b0, UNPINNED});
        repeat (5) dir_rows.push_back({8'hFF, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'hFF, 1'b0, 1'b1, 1'b0, KIND_PCR, {42{1'b1}}, 1'b0, 1'b0});
        // PCR cut off by the declared length
        dir_rows.push_back({8'h03, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h10, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h00, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h00, 1'b0, 1'b1, 1'b0, KIND_END, 42'd0, 1'b1, 1'b1});
        // extension length zero with all extension flags set
        dir_rows.push_back({8'h04, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h01, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h00, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'hE0, 1'b0, 1'b1, 1'b0, KIND_EXTHDR, 42'd7, 1'b0, 1'b0});
        dir_rows.push_back({8'hAA, 1'b0, 1'b1, 1'b0, KIND_END, 42'd0, 1'b1, 1'b1});
        // new start mid-field drops the old one without an end item
        dir_rows.push_back({8'h05, 1'b1, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h10, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h12, 1'b0, 1'b0, 1'b0, UNPINNED});
        dir_rows.push_back({8'h00, 1'b1, 1'b1, 1'b1, KIND_END, 42'd0, 1'b0, 1'b1});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].st, dir_rows[i].pin, dir_rows[i].pidx,
                      dir_rows[i].want);

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 23;
            end
            send_random_field();
        end
        s_valid <= 1'b0;

        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run: %0d bytes accepted, %0d elements checked, %0d end items flagged overrun",
                 bytes_in, elems_checked, overrun_ends);
        $display("per kind (length..end): %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
                 kind_hits[5], kind_hits[6], kind_hits[7], kind_hits[8], kind_hits[9],
                 kind_hits[10]);
        if (err_count == 0) begin
            $display("ts_adaptation_field_parser test passed");
        end else begin
            $display("ts_adaptation_field_parser test failed");
        end
        $finish;
    end

endmodule
